FILE: sv/ica_pkg.sv
// Package for the integer calculator ALU.
// Holds operator and status codes, sequencer states and the shared-unit request type.
// No dependencies.
package ica_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        FN_ADD  = 3'd0,
        FN_SUB  = 3'd1,
        FN_MUL  = 3'd2,
        FN_DIV  = 3'd3,
        FN_FACT = 3'd4,
        FN_MOD  = 3'd5,
        FN_POW  = 3'd6,
        FN_UNK  = 3'd7
    } t_func;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_UNK = 2'd2,
        ST_RSV = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_MUL_WAIT,
        S_DIV_WAIT,
        S_FACT_CHK,
        S_FACT_WAIT,
        S_POW_CHK,
        S_POW_WACC,
        S_POW_WSQ,
        S_FIN
    } t_state;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

endpackage

FILE: sv/ica_mdu.sv
// Bit-serial multiply and restoring divide unit, one bit per cycle.
// Depends on ica_pkg.
module ica_mdu import ica_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mdu_req              i_req,
    input  logic [DATA_WIDTH-1:0] i_x,
    input  logic [DATA_WIDTH-1:0] i_y,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_hi,
    output logic [DATA_WIDTH-1:0] o_lo
);

    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CW-1:0]         r_cnt, n_cnt;
    t_mdu_op               r_op, n_op;
    logic [DATA_WIDTH-1:0] r_x, n_x;
    logic [DATA_WIDTH-1:0] r_y, n_y;
    logic [DATA_WIDTH-1:0] r_hi, n_hi;
    logic [DATA_WIDTH:0]   w_sh;
    logic [DATA_WIDTH:0]   w_trial;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_x     = r_x;
        n_y     = r_y;
        n_hi    = r_hi;
        w_sh    = {r_hi, r_x[DATA_WIDTH-1]};
        w_trial = w_sh - {1'b0, r_y};
        if (r_busy) begin
            if (r_op == OP_MUL) begin
                if (r_y[0]) begin
                    n_hi = r_hi + r_x;
                end
                n_x = {r_x[DATA_WIDTH-2:0], 1'b0};
                n_y = {1'b0, r_y[DATA_WIDTH-1:1]};
            end else begin
                n_hi = w_trial[DATA_WIDTH] ? w_sh[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
                n_x  = {r_x[DATA_WIDTH-2:0], ~w_trial[DATA_WIDTH]};
            end
            n_cnt = r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end else if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(DATA_WIDTH);
            n_op   = i_req.op;
            n_x    = i_x;
            n_y    = i_y;
            n_hi   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_op <= n_op;
        r_x  <= n_x;
        r_y  <= n_y;
        r_hi <= n_hi;
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_x;

endmodule

FILE: sv/integer_calculator_alu.sv
// Top level of the integer calculator ALU: sequencer, operand and output registers.
// Depends on ica_pkg and ica_mdu.
//
// One item is in flight at a time; o_in_stall is high from the transfer until the
// result is written to the output register, which then holds it while the next
// item is taken. Add and subtract are computed in the decode state; multiply,
// divide and modulo take one pass through the shared multiply/divide unit, and
// factorial and power run a sequence of multiplies on it. The unit retires one
// operand bit per cycle.
module integer_calculator_alu import ica_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_result,
    output logic [1:0]         o_status
);

    localparam int W = DATA_WIDTH;

    t_state         r_state, n_state;
    t_func          r_func, n_func;
    logic [W-1:0]   r_a, n_a;
    logic [W-1:0]   r_b, n_b;
    logic [W-1:0]   r_acc, n_acc;
    logic [W-1:0]   r_sq, n_sq;
    logic [W-1:0]   r_e, n_e;
    logic [W-1:0]   r_i, n_i;
    t_status        r_st, n_st;
    logic           r_out_valid, n_out_valid;
    logic [31:0]    r_result, n_result;
    t_status        r_status, n_status;

    t_mdu_req       w_req;
    logic [W-1:0]   w_mx, w_my;
    logic           w_done;
    logic [W-1:0]   w_hi, w_lo;
    logic           w_neg_a, w_neg_b;
    logic [W-1:0]   w_mag_a, w_mag_b;
    logic [W-1:0]   w_ones;

    assign w_neg_a = r_a[W-1];
    assign w_neg_b = r_b[W-1];
    assign w_mag_a = w_neg_a ? (W'(0) - r_a) : r_a;
    assign w_mag_b = w_neg_b ? (W'(0) - r_b) : r_b;
    assign w_ones  = '1;

    ica_mdu #(.DATA_WIDTH(W)) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_x     (w_mx),
        .i_y     (w_my),
        .o_done  (w_done),
        .o_hi    (w_hi),
        .o_lo    (w_lo)
    );

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_a         = r_a;
        n_b         = r_b;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_e         = r_e;
        n_i         = r_i;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        n_status    = r_status;
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_mx        = r_acc;
        w_my        = r_sq;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func  = t_func'(i_func);
                    n_a     = W'(i_operand_a);
                    n_b     = W'(i_operand_b);
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_st    = ST_OK;
                n_state = S_FIN;
                case (r_func)
                    FN_ADD: n_acc = r_a + r_b;
                    FN_SUB: n_acc = r_a - r_b;
                    FN_MUL: begin
                        w_req.start = 1'b1;
                        w_mx        = r_a;
                        w_my        = r_b;
                        n_state     = S_MUL_WAIT;
                    end
                    FN_DIV, FN_MOD: begin
                        if (r_b == '0) begin
                            n_st  = ST_ERR;
                            n_acc = '0;
                        end else begin
                            w_req.start = 1'b1;
                            w_req.op    = OP_DIV;
                            w_mx        = w_mag_a;
                            w_my        = w_mag_b;
                            n_state     = S_DIV_WAIT;
                        end
                    end
                    FN_FACT: begin
                        if (w_neg_a) begin
                            n_st  = ST_ERR;
                            n_acc = '0;
                        end else begin
                            n_acc   = W'(1);
                            n_i     = W'(2);
                            n_state = S_FACT_CHK;
                        end
                    end
                    FN_POW: begin
                        if (w_neg_b) begin
                            if (r_a == '0) begin
                                n_st  = ST_ERR;
                                n_acc = '0;
                            end else if (r_a == W'(1)) begin
                                n_acc = W'(1);
                            end else if (r_a == w_ones) begin
                                n_acc = r_b[0] ? w_ones : W'(1);
                            end else begin
                                n_acc = '0;
                            end
                        end else begin
                            n_acc   = W'(1);
                            n_sq    = r_a;
                            n_e     = r_b;
                            n_state = S_POW_CHK;
                        end
                    end
                    default: begin
                        n_st  = ST_UNK;
                        n_acc = '0;
                    end
                endcase
            end
            S_MUL_WAIT: begin
                if (w_done) begin
                    n_acc   = w_hi;
                    n_state = S_FIN;
                end
            end
            S_DIV_WAIT: begin
                if (w_done) begin
                    if (r_func == FN_DIV) begin
                        n_acc = (w_neg_a != w_neg_b) ? (W'(0) - w_lo) : w_lo;
                    end else begin
                        n_acc = w_neg_a ? (W'(0) - w_hi) : w_hi;
                    end
                    n_state = S_FIN;
                end
            end
            S_FACT_CHK: begin
                if (r_i > r_a || r_acc == '0) begin
                    n_state = S_FIN;
                end else begin
                    w_req.start = 1'b1;
                    w_mx        = r_acc;
                    w_my        = r_i;
                    n_state     = S_FACT_WAIT;
                end
            end
            S_FACT_WAIT: begin
                if (w_done) begin
                    n_acc   = w_hi;
                    n_i     = r_i + W'(1);
                    n_state = S_FACT_CHK;
                end
            end
            S_POW_CHK: begin
                if (r_e == '0) begin
                    n_state = S_FIN;
                end else if (r_e[0]) begin
                    w_req.start = 1'b1;
                    w_mx        = r_acc;
                    w_my        = r_sq;
                    n_state     = S_POW_WACC;
                end else begin
                    w_req.start = 1'b1;
                    w_mx        = r_sq;
                    w_my        = r_sq;
                    n_state     = S_POW_WSQ;
                end
            end
            S_POW_WACC: begin
                if (w_done) begin
                    n_acc       = w_hi;
                    w_req.start = 1'b1;
                    w_mx        = r_sq;
                    w_my        = r_sq;
                    n_state     = S_POW_WSQ;
                end
            end
            S_POW_WSQ: begin
                if (w_done) begin
                    n_sq    = w_hi;
                    n_e     = {1'b0, r_e[W-1:1]};
                    n_state = S_POW_CHK;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_result    = (r_st == ST_OK) ? 32'(r_acc) : 32'd0;
                    n_status    = r_st;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_func   <= n_func;
        r_a      <= n_a;
        r_b      <= n_b;
        r_acc    <= n_acc;
        r_sq     <= n_sq;
        r_e      <= n_e;
        r_i      <= n_i;
        r_st     <= n_st;
        r_result <= n_result;
        r_status <= n_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;
    assign o_status    = r_status;

endmodule

FILE: sv/ica_checker.sv
// Port-level checker for the integer calculator ALU, bound to the top level.
// Depends on ica_pkg.
module ica_props import ica_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_result,
    input logic [1:0]         o_status
);

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status != ST_RSV))
        else $error("reserved status code");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_result == 32'sd0))
        else $error("nonzero result with error status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_result)
            && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind integer_calculator_alu ica_props u_ica_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_result    (o_result),
    .o_status    (o_status)
);
